// ===== rtl/assert_macros.svh =====
// Assertion helper macros for the RTL file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/psz_pkg.sv =====
// Package: widths, constants, micro-op table and thresholds of the point splat shader.
`timescale 1ns / 1ps
package psz_pkg;

  // Default screen size
  localparam int SCREEN_WIDTH_DEF  = 60;
  localparam int SCREEN_HEIGHT_DEF = 29;

  // Port widths
  localparam int COORD_W    = 16;
  localparam int CFG_W      = 16;
  localparam int IN_DATA_W  = 6 * COORD_W;
  localparam int COL_OUT_W  = 6;
  localparam int ROW_OUT_W  = 5;
  localparam int SHADE_W    = 3;
  localparam int OUT_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic REG_COS = 1'b0;
  localparam logic REG_SIN = 1'b1;

  // Opcodes carried in tuser
  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  // Internal datapath widths
  localparam int MUL_W  = 32;          // shared multiplier operand width
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 50;          // rotated coordinates, Q.36
  localparam int DIV_W  = 64;          // dividend / quotient
  localparam int DEN_W  = 49;          // divisor (positive depth)
  localparam int Q_W    = DIV_W - 8 + 1;
  localparam int NORM_W = 22;          // normal components, Q.8
  localparam int SQ_W   = 44;
  localparam int K_W    = 21;
  localparam int KM_W   = 68;
  localparam int M2_LO_W = 20;

  localparam int COL_OFFSET = 30;
  localparam int ROW_OFFSET = 15;
  localparam logic signed [ACC_W-1:0] DEPTH_PUSH = 50'sd70 <<< 36;
  localparam logic [7:0] DEPTH_EMPTY = 8'hFF;

  localparam int ROT_STEPS = 11;

  // Threshold indexes, in the order they are tried
  localparam logic [2:0] TH_FACE = 3'd0;
  localparam logic [2:0] TH_K5   = 3'd1;
  localparam logic [2:0] TH_K4   = 3'd2;
  localparam logic [2:0] TH_K3   = 3'd3;
  localparam logic [2:0] TH_K2   = 3'd4;
  localparam logic [2:0] TH_K1   = 3'd5;
  localparam logic [2:0] SHADE_BASE = 3'd6;

  // Rotation micro-op fields
  typedef enum logic [1:0] {OPA_A, OPA_B, OPA_D, OPA_U} opa_t;
  typedef enum logic {OPB_COS, OPB_SIN} opb_t;
  typedef enum logic [1:0] {DST_X, DST_Y, DST_Z, DST_U} dst_t;

  typedef struct packed {
    opa_t opa;
    opb_t opb;
    dst_t dst;
    logic neg;
    logic shl;   // shift product left by 14 before accumulating
  } rot_op_t;

  // X = ac<<14 - bsc - dss, Y = as<<14 + bcc + dcs, Z = (dc - bs)<<14
  function automatic rot_op_t rot_op(input logic [3:0] step);
    rot_op_t op;
    case (step)
      4'd0:    op = '{OPA_A, OPB_COS, DST_X, 1'b0, 1'b1};
      4'd1:    op = '{OPA_A, OPB_SIN, DST_Y, 1'b0, 1'b1};
      4'd2:    op = '{OPA_B, OPB_SIN, DST_Z, 1'b1, 1'b1};
      4'd3:    op = '{OPA_B, OPB_SIN, DST_U, 1'b0, 1'b0};
      4'd4:    op = '{OPA_U, OPB_COS, DST_X, 1'b1, 1'b0};
      4'd5:    op = '{OPA_B, OPB_COS, DST_U, 1'b0, 1'b0};
      4'd6:    op = '{OPA_U, OPB_COS, DST_Y, 1'b0, 1'b0};
      4'd7:    op = '{OPA_D, OPB_SIN, DST_U, 1'b0, 1'b0};
      4'd8:    op = '{OPA_U, OPB_SIN, DST_X, 1'b1, 1'b0};
      4'd9:    op = '{OPA_U, OPB_COS, DST_Y, 1'b0, 1'b0};
      4'd10:   op = '{OPA_D, OPB_COS, DST_Z, 1'b0, 1'b1};
      default: op = '{OPA_D, OPB_COS, DST_Z, 1'b0, 1'b1};
    endcase
    return op;
  endfunction

  // Squared-cosine thresholds in Q.20 (facing, then shade levels 5 down to 1)
  function automatic logic [K_W-1:0] thresh_k(input logic [2:0] idx);
    logic [K_W-1:0] k;
    case (idx)
      TH_FACE: k = 21'd261180;
      TH_K5:   k = 21'd1790327;
      TH_K4:   k = 21'd1049411;
      TH_K3:   k = 21'd525252;
      TH_K2:   k = 21'd522361;
      TH_K1:   k = 21'd1570451;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/point_splat_zbuffer_shader.sv =====
// Top level: depth-buffered point splat shader for a rotating torus.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A draw transaction (tuser 1) rotates the tube centre and the surface point
// with one shared 32x32 multiplier, projects x and y with a shift-subtract
// divider of one quotient bit per cycle (one 64-bit run per axis), checks
// the depth store, and grades the normal against six thresholds. A draw
// that passes every test waits in the output state until the output
// register has room; a point rejected early returns to idle with no result.
// A clear transaction (tuser 0) sweeps all SCREEN_WIDTH*SCREEN_HEIGHT cells
// of the depth store (1740 at the default size), one cell per cycle; the
// same sweep runs after reset. s_tready is low while either is in progress.
// Configuration writes are taken at any time and should be done when idle.
module point_splat_zbuffer_shader #(
  parameter int SCREEN_WIDTH  = psz_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = psz_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // point_x, point_y, point_z, centre_x, centre_y, centre_z (16 bits each)
  input  logic [psz_pkg::IN_DATA_W-1:0]     s_tdata,
  // opcode
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // pixel_column [5:0], pixel_row [10:6], shade_level [13:11], zero pad
  output logic [psz_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [psz_pkg::CFG_W-1:0]         cfg_wdata
);
  import psz_pkg::*;

  localparam int COLW    = $clog2(SCREEN_WIDTH);
  localparam int ROWW    = $clog2(SCREEN_HEIGHT);
  localparam int CELLS   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int CELL_AW = $clog2(CELLS);
  localparam logic signed [Q_W-1:0] COL_LIMIT = Q_W'(SCREEN_WIDTH);
  localparam logic signed [Q_W-1:0] ROW_LIMIT = Q_W'(SCREEN_HEIGHT);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ROT, ST_ZCHK, ST_DIV, ST_PROJ, ST_ADDR, ST_DEPTH,
    ST_NORM, ST_SQ, ST_MAG, ST_KLO, ST_KHI, ST_KCMP, ST_OUT
  } state_t;

  state_t state;

  // Configuration
  logic signed [COORD_W-1:0] cos_angle, sin_angle;

  // Latched input transaction
  logic signed [COORD_W-1:0] pt_x, pt_y, pt_z, ce_x, ce_y, ce_z;

  // Rotation: index 0 is the tube centre, index 1 the surface point
  logic signed [ACC_W-1:0] rx [2];
  logic signed [ACC_W-1:0] ry [2];
  logic signed [ACC_W-1:0] rz [2];
  logic signed [MUL_W-1:0] u_r;
  logic                    vec;
  logic [3:0]              step;

  // Projection / divider
  logic signed [ACC_W-1:0] zp;
  logic [DIV_W-1:0]        div_q;
  logic [DEN_W-1:0]        div_r;
  logic [5:0]              div_cnt;
  logic                    div_neg;
  logic                    axis;
  logic [COLW-1:0]         col;
  logic [ROWW-1:0]         row;
  logic signed [NORM_W-1:0] px8, py8;

  // Normal and shading
  logic signed [NORM_W-1:0] nx, ny, nz, w;
  logic [SQ_W-1:0]          sq_n [4];
  logic [SQ_W-1:0]          m2;
  logic [KM_W-1:0]          km;
  logic [2:0]               th;
  logic [SHADE_W-1:0]       shade_r;

  // Output register
  logic [COL_OUT_W-1:0] out_col;
  logic [ROW_OUT_W-1:0] out_row;
  logic [SHADE_W-1:0]   out_shade;

  // Depth store
  logic [7:0]         depth_mem [CELLS];
  logic [7:0]         mem_q;
  logic [CELL_AW-1:0] clr_idx;
  logic [CELL_AW-1:0] cell_addr;
  logic [CELL_AW-1:0] mem_addr;
  logic               mem_we;
  logic [7:0]         mem_wd;

  // ---------------------------------------------------------------
  // Shared multiplier operand selection
  rot_op_t                 rop;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] term;
  logic [K_W-1:0]          kval;

  assign rop  = rot_op(step);
  assign kval = thresh_k(th);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_ROT: begin
        case (rop.opa)
          OPA_A:   mul_a = MUL_W'(vec ? pt_x : ce_x);
          OPA_B:   mul_a = MUL_W'(vec ? pt_y : ce_y);
          OPA_D:   mul_a = MUL_W'(vec ? pt_z : ce_z);
          default: mul_a = u_r;
        endcase
        mul_b = (rop.opb == OPB_COS) ? MUL_W'(cos_angle) : MUL_W'(sin_angle);
      end
      ST_SQ: begin
        case (step[1:0])
          2'd0:    mul_a = MUL_W'(nx);
          2'd1:    mul_a = MUL_W'(ny);
          2'd2:    mul_a = MUL_W'(nz);
          default: mul_a = MUL_W'(w);
        endcase
        mul_b = mul_a;
      end
      ST_KLO: begin
        mul_a = $signed(MUL_W'(kval));
        mul_b = $signed(MUL_W'(m2[M2_LO_W-1:0]));
      end
      ST_KHI: begin
        mul_a = $signed(MUL_W'(kval));
        mul_b = $signed(MUL_W'(m2[SQ_W-1:M2_LO_W]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign term = rop.shl ? (ACC_W'(prod) <<< 14) : ACC_W'(prod);

  // ---------------------------------------------------------------
  // Divider datapath
  logic signed [ACC_W-1:0] zp_c;
  logic [ACC_W-1:0]        mag_x, mag_y;
  logic [DIV_W-1:0]        dvd_x, dvd_y;
  logic [DEN_W-1:0]        den;
  logic [DEN_W:0]          rem_sh;
  logic [DEN_W+1:0]        diff;

  assign zp_c  = rz[1] + DEPTH_PUSH;
  assign den   = zp[DEN_W-1:0];
  assign mag_x = rx[1][ACC_W-1] ? -rx[1] : rx[1];
  assign mag_y = ry[1][ACC_W-1] ? -ry[1] : ry[1];
  // |v| * 40 * 256
  assign dvd_x = (DIV_W'(mag_x) << 13) + (DIV_W'(mag_x) << 11);
  assign dvd_y = (DIV_W'(mag_y) << 13) + (DIV_W'(mag_y) << 11);
  assign rem_sh = {div_r, div_q[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, den};

  // Projection result: coordinate with screen offset and Q.8 value
  logic [Q_W-2:0]           q_mag;
  logic signed [Q_W-1:0]    q_s, coord;
  logic signed [NORM_W-1:0] q8;
  logic                     on_screen;

  always_comb begin
    q_mag = div_q[DIV_W-1:8];
    q_s   = div_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    q8    = div_neg ? -$signed(div_q[NORM_W-1:0]) : $signed(div_q[NORM_W-1:0]);
    if (axis) begin
      coord     = q_s + Q_W'(ROW_OFFSET);
      on_screen = (coord >= 0) && (coord < ROW_LIMIT);
    end else begin
      coord     = q_s + Q_W'(COL_OFFSET);
      on_screen = (coord >= 0) && (coord < COL_LIMIT);
    end
  end

  // ---------------------------------------------------------------
  // Normal vector
  function automatic logic signed [NORM_W-1:0] trunc28(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    mag = v[ACC_W-1] ? -v : v;
    mag = mag >> 28;
    return v[ACC_W-1] ? -NORM_W'(mag) : NORM_W'(mag);
  endfunction

  logic signed [NORM_W-1:0] nx_c, ny_c, nz_c;
  logic [SQ_W-1:0]          m2_c;

  assign nx_c = px8 - trunc28(rx[0]);
  assign ny_c = py8 - trunc28(ry[0]);
  assign nz_c = trunc28(rz[1] - rz[0]);
  assign m2_c = sq_n[0] + sq_n[1] + sq_n[2];

  // Threshold compare
  logic [KM_W-1:0]    sqz20, sqw20;
  logic               k_reject, k_hit, k_emit, k_done;
  logic [SHADE_W-1:0] shade_c;

  assign sqz20 = KM_W'({sq_n[2], 20'b0});
  assign sqw20 = KM_W'({sq_n[3], 20'b0});

  always_comb begin
    k_reject = 1'b0;
    k_hit    = 1'b0;
    case (th)
      TH_FACE:             k_reject = (nz > 0) && (sqz20 >= km);
      TH_K5, TH_K4, TH_K3: k_hit    = (w > 0) && (sqw20 > km);
      TH_K2, TH_K1:        k_hit    = (w >= 0) || (sqw20 < km);
      default: begin
        k_reject = 1'b0;
        k_hit    = 1'b0;
      end
    endcase
    k_emit  = (th != TH_FACE) && (k_hit || (th == TH_K1));
    shade_c = k_hit ? SHADE_W'(SHADE_BASE - th) : '0;
  end

  assign k_done = (state == ST_KCMP) && k_emit;

  // ---------------------------------------------------------------
  // Depth store port
  assign cell_addr = CELL_AW'(row * SCREEN_WIDTH) + CELL_AW'(col);
  assign mem_addr  = (state == ST_CLEAR) ? clr_idx : cell_addr;
  assign mem_we    = (state == ST_CLEAR) || k_done;
  assign mem_wd    = (state == ST_CLEAR) ? DEPTH_EMPTY : zp[43:36];

  always_ff @(posedge clk) begin
    if (mem_we) depth_mem[mem_addr] <= mem_wd;
    mem_q <= depth_mem[mem_addr];
  end

  // ---------------------------------------------------------------
  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_angle <= 16'sd16384;
      sin_angle <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_COS) cos_angle <= cfg_wdata;
      else if (cfg_addr == REG_SIN) sin_angle <= cfg_wdata;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {{(OUT_DATA_W - COL_OUT_W - ROW_OUT_W - SHADE_W){1'b0}},
                     out_shade, out_row, out_col};

  // ---------------------------------------------------------------
  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      m_tvalid <= 1'b0;
      step     <= '0;
      vec      <= 1'b0;
      th       <= TH_FACE;
      axis     <= 1'b0;
      div_cnt  <= '0;
    end else begin
      // ST_OUT reloads the output register itself
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;

      case (state)
        // Sweep the depth store to empty
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CELL_AW'(CELLS - 1)) state <= ST_IDLE;
        end

        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == OP_CLEAR) begin
              clr_idx <= '0;
              state   <= ST_CLEAR;
            end else begin
              pt_x <= s_tdata[15:0];
              pt_y <= s_tdata[31:16];
              pt_z <= s_tdata[47:32];
              ce_x <= s_tdata[63:48];
              ce_y <= s_tdata[79:64];
              ce_z <= s_tdata[95:80];
              for (int i = 0; i < 2; i++) begin
                rx[i] <= '0;
                ry[i] <= '0;
                rz[i] <= '0;
              end
              step  <= '0;
              vec   <= 1'b0;
              state <= ST_ROT;
            end
          end
        end

        // One rotation micro-op per cycle
        ST_ROT: begin
          case (rop.dst)
            DST_X:   rx[vec] <= rop.neg ? rx[vec] - term : rx[vec] + term;
            DST_Y:   ry[vec] <= rop.neg ? ry[vec] - term : ry[vec] + term;
            DST_Z:   rz[vec] <= rop.neg ? rz[vec] - term : rz[vec] + term;
            default: u_r <= prod[MUL_W-1:0];
          endcase
          if (step == 4'(ROT_STEPS - 1)) begin
            step <= '0;
            if (vec) state <= ST_ZCHK;
            else vec <= 1'b1;
          end else begin
            step <= step + 1'b1;
          end
        end

        // Behind-viewer test, start x projection
        ST_ZCHK: begin
          if (zp_c <= 0) begin
            state <= ST_IDLE;
          end else begin
            zp      <= zp_c;
            div_q   <= dvd_x;
            div_r   <= '0;
            div_neg <= rx[1][ACC_W-1];
            div_cnt <= '0;
            axis    <= 1'b0;
            state   <= ST_DIV;
          end
        end

        // Restoring divide, one quotient bit per cycle
        ST_DIV: begin
          if (!diff[DEN_W+1]) begin
            div_r <= diff[DEN_W-1:0];
            div_q <= {div_q[DIV_W-2:0], 1'b1};
          end else begin
            div_r <= rem_sh[DEN_W-1:0];
            div_q <= {div_q[DIV_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 6'(DIV_W - 1)) state <= ST_PROJ;
        end

        ST_PROJ: begin
          if (!on_screen) begin
            state <= ST_IDLE;
          end else if (!axis) begin
            col     <= coord[COLW-1:0];
            px8     <= q8;
            div_q   <= dvd_y;
            div_r   <= '0;
            div_neg <= ry[1][ACC_W-1];
            div_cnt <= '0;
            axis    <= 1'b1;
            state   <= ST_DIV;
          end else begin
            row   <= coord[ROWW-1:0];
            py8   <= q8;
            state <= ST_ADDR;
          end
        end

        // Store read is in flight this cycle
        ST_ADDR: state <= ST_DEPTH;

        ST_DEPTH: begin
          if (DEN_W'({mem_q, 36'b0}) > zp[DEN_W-1:0]) state <= ST_NORM;
          else state <= ST_IDLE;
        end

        ST_NORM: begin
          nx    <= nx_c;
          ny    <= ny_c;
          nz    <= nz_c;
          w     <= -ny_c - nz_c;
          step  <= '0;
          state <= ST_SQ;
        end

        ST_SQ: begin
          sq_n[step[1:0]] <= prod[SQ_W-1:0];
          step <= step + 1'b1;
          if (step[1:0] == 2'd3) state <= ST_MAG;
        end

        // Zero normal counts as facing away
        ST_MAG: begin
          if (m2_c == '0) begin
            state <= ST_IDLE;
          end else begin
            m2    <= m2_c;
            th    <= TH_FACE;
            state <= ST_KLO;
          end
        end

        ST_KLO: begin
          km    <= KM_W'($unsigned(prod));
          state <= ST_KHI;
        end

        ST_KHI: begin
          km    <= km + (KM_W'($unsigned(prod)) << M2_LO_W);
          state <= ST_KCMP;
        end

        ST_KCMP: begin
          if (k_reject) begin
            state <= ST_IDLE;
          end else if (k_emit) begin
            shade_r <= shade_c;
            state   <= ST_OUT;
          end else begin
            th    <= th + 1'b1;
            state <= ST_KLO;
          end
        end

        // Wait for room in the output register
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            out_col   <= COL_OUT_W'(col);
            out_row   <= ROW_OUT_W'(row);
            out_shade <= shade_r;
            m_tvalid  <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  `ASSERT_IMPLIES(a_div_rem_below_den, state == ST_DIV, div_r < den,
    "divider remainder not below divisor")
  `ASSERT_IMPLIES(a_draw_depth_not_empty, mem_we && state != ST_CLEAR,
    mem_wd != DEPTH_EMPTY, "draw wrote the empty depth code")
  `ASSERT_IMPLIES(a_shade_range, m_tvalid, out_shade <= 3'd5,
    "shade level out of range")
  `ASSERT_NEXT(a_no_early_result, s_tvalid && s_tready, !$rose(m_tvalid),
    "result appeared right after an accepted transaction")

endmodule

// ===== verif/tb_point_splat_zbuffer_shader.sv =====
// Testbench for the point splat z-buffer shader: queued stimulus, self-checking predictor.
`timescale 1ns / 1ps
module tb_point_splat_zbuffer_shader;
  import psz_pkg::*;

  localparam int SCR_W = 60;
  localparam int SCR_H = 29;
  localparam int N_CELLS = SCR_W * SCR_H;
  localparam longint Q36 = 64'sd1 << 36;
  localparam longint Q36_Q8 = 64'sd1 << 28;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_WAIT = 2000;  // longer than a full clear sweep

  typedef struct {
    logic op;
    logic [15:0] px, py, pz, cx, cy, cz;
  } point_item_t;

  typedef struct {
    logic [5:0] col;
    logic [4:0] row;
    logic [2:0] shade;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic cfg_addr = REG_COS;
  logic [CFG_W-1:0] cfg_wdata = '0;

  point_item_t pending_items[$];
  pixel_t expected_pixels[$];
  logic [7:0] depth_copy[N_CELLS];
  longint cos_copy, sin_copy;
  int errors = 0;
  int n_draws = 0, n_clears = 0, n_pixels = 0;
  int shade_hits[6];
  bit quiet = 1'b0;
  int stall_cnt = 0;

  point_splat_zbuffer_shader i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned square(input longint v);
    longint unsigned a;
    a = (v < 0) ? -v : v;
    return a * a;
  endfunction

  // Rotation of one Q8.8 vector into Q.36, depth push left out
  function automatic void rotate_q36(input longint a, b, d,
                                     output longint rx, ry, rz);
    rx = a * cos_copy * 16384 - b * sin_copy * cos_copy - d * sin_copy * sin_copy;
    ry = a * sin_copy * 16384 + b * cos_copy * cos_copy + d * cos_copy * sin_copy;
    rz = (d * cos_copy - b * sin_copy) * 16384;
  endfunction

  // trunc(num*40/den), plus the Q.8 form of the same ratio
  function automatic longint project_q(input longint num, den, output longint q8);
    longint n, q, r;
    n = num * 40;
    q = n / den;
    r = n - q * den;
    q8 = q * 256 + (r * 256) / den;
    return q;
  endfunction

  // Shade the point and update the depth copy; returns 1 when a pixel is written
  function automatic bit shade_point(input point_item_t it, output pixel_t pix);
    longint px, py, pz, cx, cy, cz, zp, px8, py8, col, row, nx, ny, nz, w;
    longint unsigned m2;
    int cell_idx;
    logic [2:0] lvl;
    rotate_q36(longint'($signed(it.px)), longint'($signed(it.py)),
               longint'($signed(it.pz)), px, py, pz);
    rotate_q36(longint'($signed(it.cx)), longint'($signed(it.cy)),
               longint'($signed(it.cz)), cx, cy, cz);
    zp = pz + 70 * Q36;
    if (zp <= 0) return 1'b0;
    col = project_q(px, zp, px8) + 30;
    row = project_q(py, zp, py8) + 15;
    if (col < 0 || col >= SCR_W || row < 0 || row >= SCR_H) return 1'b0;
    cell_idx = int'(row * SCR_W + col);
    if (longint'(depth_copy[cell_idx]) * Q36 <= zp) return 1'b0;
    nx = px8 - cx / Q36_Q8;
    ny = py8 - cy / Q36_Q8;
    nz = (pz - cz) / Q36_Q8;
    m2 = square(nx) + square(ny) + square(nz);
    if (m2 == 0) return 1'b0;
    if (nz > 0 && (square(nz) << 20) >= 64'd261180 * m2) return 1'b0;
    w = -ny - nz;
    if (w > 0 && (square(w) << 20) > 64'd1790327 * m2) lvl = 3'd5;
    else if (w > 0 && (square(w) << 20) > 64'd1049411 * m2) lvl = 3'd4;
    else if (w > 0 && (square(w) << 20) > 64'd525252 * m2) lvl = 3'd3;
    else if (w >= 0 || (square(w) << 20) < 64'd522361 * m2) lvl = 3'd2;
    else if (w >= 0 || (square(w) << 20) < 64'd1570451 * m2) lvl = 3'd1;
    else lvl = 3'd0;
    depth_copy[cell_idx] = 8'(zp >>> 36);
    pix.col = 6'(col);
    pix.row = 5'(row);
    pix.shade = lvl;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Driver: one transaction per accept, random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 16)) begin
        s_tvalid <= 1'b1;
        s_tuser <= pending_items[0].op;
        s_tdata <= {pending_items[0].cz, pending_items[0].cy, pending_items[0].cx,
                    pending_items[0].pz, pending_items[0].py, pending_items[0].px};
        void'(pending_items.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= quiet || ($urandom_range(99) >= 16);
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    point_item_t it;
    pixel_t pix, exp_pix;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        it.op = s_tuser;
        {it.cz, it.cy, it.cx, it.pz, it.py, it.px} = s_tdata;
        if (it.op == OP_CLEAR) begin
          n_clears++;
          foreach (depth_copy[i]) depth_copy[i] = 8'hFF;
        end else begin
          n_draws++;
          if (shade_point(it, pix)) expected_pixels.push_back(pix);
        end
      end
      if (m_tvalid && m_tready) begin
        pix.col = m_tdata[5:0];
        pix.row = m_tdata[10:6];
        pix.shade = m_tdata[13:11];
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel col %0d row %0d shade %0d",
                                    pix.col, pix.row, pix.shade));
        end else begin
          exp_pix = expected_pixels.pop_front();
          n_pixels++;
          if (exp_pix.shade < 6) shade_hits[exp_pix.shade]++;
          if (pix.col !== exp_pix.col)
            report_mismatch($sformatf("column %0d, expected %0d", pix.col, exp_pix.col));
          if (pix.row !== exp_pix.row)
            report_mismatch($sformatf("row %0d, expected %0d", pix.row, exp_pix.row));
          if (pix.shade !== exp_pix.shade)
            report_mismatch($sformatf("shade %0d, expected %0d", pix.shade, exp_pix.shade));
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_COS) cos_copy = longint'($signed(val));
    else sin_copy = longint'($signed(val));
  endtask

  task automatic add_item(input logic op, input int px, py, pz, cx, cy, cz);
    point_item_t it;
    it.op = op;
    it.px = 16'(px); it.py = 16'(py); it.pz = 16'(pz);
    it.cx = 16'(cx); it.cy = 16'(cy); it.cz = 16'(cz);
    pending_items.push_back(it);
  endtask

  // Torus surface point with its tube centre, in Q8.8
  task automatic add_torus_point();
    real th, ph, r_tube, r_ring, ccx, ccy;
    th = $urandom_range(6283) / 1000.0;
    ph = $urandom_range(6283) / 1000.0;
    r_ring = 8.0 + $urandom_range(24);
    r_tube = 2.0 + $urandom_range(10);
    ccx = r_ring * $cos(th);
    ccy = r_ring * $sin(th);
    add_item(OP_DRAW,
             $rtoi(256.0 * (ccx + r_tube * $cos(th) * $cos(ph))),
             $rtoi(256.0 * (ccy + r_tube * $sin(th) * $cos(ph))),
             $rtoi(256.0 * r_tube * $sin(ph)),
             $rtoi(256.0 * ccx), $rtoi(256.0 * ccy), 0);
  endtask

  task automatic add_random_items(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 2) begin
        add_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if ($urandom_range(99) < 12) begin
        add_item(1'($urandom_range(1)), $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom);
      end else begin
        add_torus_point();
      end
    end
  endtask

  // Wait until every transaction is sent and answered, then past any sweep
  task automatic drain();
    while (pending_items.size() > 0 || s_tvalid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_angle(input logic [15:0] c, input logic [15:0] s);
    write_reg(REG_COS, c);
    write_reg(REG_SIN, s);
  endtask

  initial begin
    real a;
    cos_copy = 16384;
    sin_copy = 0;
    foreach (depth_copy[i]) depth_copy[i] = 8'hFF;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: default angle
    add_item(OP_DRAW, 0, 0, 0, 0, 0, 0);                   // zero normal
    add_item(OP_DRAW, 0, 0, -70 * 256, 0, 0, 0);           // depth exactly zero
    add_item(OP_DRAW, 0, 0, -32768, 0, 0, 0);              // behind viewer
    add_item(OP_DRAW, 32767, 0, 0, 0, 0, 0);               // off screen right
    add_item(OP_DRAW, -32768, 0, 0, 0, 0, 0);              // off screen left
    add_item(OP_DRAW, 0, 32767, 0, 0, 0, 0);               // off screen bottom
    add_item(OP_DRAW, 0, -32768, 0, 0, 0, 0);              // off screen top
    add_item(OP_DRAW, 0, 0, -256, 0, 0, 0);                // normal toward viewer
    add_item(OP_DRAW, 0, 0, -256, 0, 0, 0);                // same cell, depth test
    add_item(OP_DRAW, 0, 0, -512, 0, 0, 0);                // nearer, passes
    add_item(OP_DRAW, 256, 0, 256, 256, 0, 0);             // facing away
    add_item(OP_DRAW, 2560, -256, 0, 2560, 0, 256);        // facet with w > 0, shade level 2
    add_item(OP_DRAW, 2560, 2560, 0, 2560, 1280, -256);    // facet with w < 0, shade level 2
    add_item(OP_DRAW, -2560, 512, -256, -2560, 0, 0);
    add_item(OP_DRAW, 1024, -1024, 32767, 1024, -1024, 32767);  // far depth
    add_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
    add_item(OP_DRAW, 0, 0, -256, 0, 0, 0);                // cell freed by clear
    add_item(OP_CLEAR, -1, -1, -1, -1, -1, -1);
    add_random_items(130);
    drain();

    // Sweep of angles, extremes and out-of-range register values
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_angle(16'(-16384), 16'(0));
        1: set_angle(16'(0), 16'(16384));
        2: set_angle(16'(0), 16'(-16384));
        3: set_angle(16'(11585), 16'(11585));
        4: set_angle(16'h7FFF, 16'h8000);
        default: begin
          a = $urandom_range(6283) / 1000.0;
          set_angle(16'($rtoi(16384.0 * $cos(a))), 16'($rtoi(16384.0 * $sin(a))));
        end
      endcase
      quiet = (ph == 3);
      add_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
      add_random_items(ph == 4 ? 60 : 130);
      drain();
    end
    quiet = 1'b0;

    $display("covered %0d draws and %0d clears, %0d pixels checked over 8 angle settings",
             n_draws, n_clears, n_pixels);
    $display("pixels per shade 0..5: %0d %0d %0d %0d %0d %0d", shade_hits[0],
             shade_hits[1], shade_hits[2], shade_hits[3], shade_hits[4], shade_hits[5]);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
